>>> sv/nmea_pkg.sv
// Shared types and constants for the NMEA sentence checker.
// Holds the character codes, the token passed from the front end to the back end,
// and the sizes of the token queue and of the result word. No dependencies.
package nmea_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;

    // Sentence layout.
    localparam logic [2:0] TALKER_LEN  = 3'd5;
    localparam logic [2:0] TIME_FIELD  = 3'd5;
    localparam logic [2:0] FIELD_MAX   = 3'd7;
    localparam logic [2:0] TOKEN_MAX   = 3'd7;
    localparam logic [2:0] TIME_DIGITS = 3'd6;
    localparam logic [1:0] HEX_DIGITS  = 2'd2;

    // Reset value of the timezone register.
    localparam logic signed [4:0] TZ_RESET = 5'sd2;

    // Token queue and result word sizes.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam int OUT_DATA_W  = 48;

    // Kind of token handed from the front end to the back end.
    typedef enum logic [1:0] {
        TOK_START,
        TOK_END,
        TOK_CHAR
    } tok_kind_t;

    // One classified character of a sentence.
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] ch;
        logic       is_star;
        logic       is_comma;
        logic       is_digit;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_g;
        logic       is_n_or_p;
        logic       is_l;
    } token_t;

endpackage

>>> sv/nmea_front.sv
// Front end of the NMEA sentence checker: frames sentences and classifies bytes.
// Produces nmea_pkg::token_t tokens for the token queue; depends on nmea_pkg.
module nmea_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    output logic            push,
    output nmea_pkg::token_t tok
);

    logic                listening_reg;
    logic                listening_next;
    logic                is_dollar;
    logic                is_line_end;
    nmea_pkg::tok_kind_t kind_sel;

    assign is_dollar   = (in_byte == nmea_pkg::CHAR_DOLLAR);
    assign is_line_end = (in_byte == nmea_pkg::CHAR_CR) || (in_byte == nmea_pkg::CHAR_LF);

    // Framing: idle bytes other than a dollar sign are dropped.
    always_comb
    begin
        listening_next = listening_reg;
        push           = 1'b0;
        kind_sel       = nmea_pkg::TOK_CHAR;
        if (in_valid)
        begin
            if (!listening_reg)
            begin
                if (is_dollar)
                begin
                    listening_next = 1'b1;
                    push           = 1'b1;
                    kind_sel       = nmea_pkg::TOK_START;
                end
            end
            else if (is_line_end)
            begin
                listening_next = 1'b0;
                push           = 1'b1;
                kind_sel       = nmea_pkg::TOK_END;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    // Character classes that the back end needs.
    always_comb
    begin
        tok.kind      = kind_sel;
        tok.ch        = in_byte;
        tok.is_star   = (in_byte == nmea_pkg::CHAR_STAR);
        tok.is_comma  = (in_byte == nmea_pkg::CHAR_COMMA);
        tok.is_digit  = (in_byte >= nmea_pkg::CHAR_0) && (in_byte <= nmea_pkg::CHAR_9);
        tok.is_g      = (in_byte == nmea_pkg::CHAR_G);
        tok.is_n_or_p = (in_byte == nmea_pkg::CHAR_N) || (in_byte == nmea_pkg::CHAR_P);
        tok.is_l      = (in_byte == nmea_pkg::CHAR_L);
        tok.hex_ok    = 1'b1;
        tok.hex_val   = 4'd0;
        if (tok.is_digit)
        begin
            tok.hex_val = in_byte[3:0];
        end
        else if ((in_byte >= nmea_pkg::CHAR_UA) && (in_byte <= nmea_pkg::CHAR_UF))
        begin
            tok.hex_val = 4'(in_byte - nmea_pkg::CHAR_UA + 8'd10);
        end
        else if ((in_byte >= nmea_pkg::CHAR_LA) && (in_byte <= nmea_pkg::CHAR_LF_HEX))
        begin
            tok.hex_val = 4'(in_byte - nmea_pkg::CHAR_LA + 8'd10);
        end
        else
        begin
            tok.hex_ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listening_reg <= 1'b0;
        end
        else
        begin
            listening_reg <= listening_next;
        end
    end

endmodule

>>> sv/nmea_queue.sv
// Short token queue between the front end and the back end.
// Stores nmea_pkg::token_t entries; depth and pointer widths come from nmea_pkg.
module nmea_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nmea_pkg::token_t push_tok,
    output logic             full,
    input  logic             pop,
    output nmea_pkg::token_t pop_tok,
    output logic             empty
);

    nmea_pkg::token_t                   mem [nmea_pkg::QUEUE_DEPTH];
    logic [nmea_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [nmea_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [nmea_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [nmea_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == nmea_pkg::QUEUE_CNT_W'(nmea_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_tok = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/nmea_back.sv
// Back end of the NMEA sentence checker: checksum, field parsing and result register.
// Consumes nmea_pkg::token_t tokens from the queue; depends on nmea_pkg.
module nmea_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tok_valid,
    input  nmea_pkg::token_t                tok,
    output logic                            tok_pop,
    input  logic signed [4:0]               tz,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nmea_pkg::OUT_DATA_W-1:0] out_data
);

    logic        after_star_reg, after_star_next;
    logic [7:0]  xor_reg, xor_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [7:0]  hex_reg, hex_next;
    logic        hex_bad_reg, hex_bad_next;
    logic [2:0]  field_reg, field_next;
    logic [2:0]  tpos_reg, tpos_next;
    logic        tmatch_reg, tmatch_next;
    logic [2:0]  tdig_reg, tdig_next;
    logic        tstop_reg, tstop_next;
    logic [23:0] bcd_reg, bcd_next;
    logic        out_valid_reg, out_valid_next;
    logic [nmea_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        slot_free;
    logic        letter_ok;
    logic        pos;
    logic        tv;
    logic        ok;
    logic [6:0]  hour_utc;
    logic [6:0]  minute_bin;
    logic [6:0]  second_bin;
    logic signed [7:0] hour_sum;
    logic [6:0]  hour_out;

    assign slot_free = !out_valid_reg || out_ready;
    assign tok_pop   = tok_valid && ((tok.kind != nmea_pkg::TOK_END) || slot_free);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Expected letter of the talker and sentence name at the current place.
    always_comb
    begin
        unique case (tpos_reg)
            3'd0:    letter_ok = tok.is_g;
            3'd1:    letter_ok = tok.is_n_or_p;
            3'd2:    letter_ok = tok.is_g;
            3'd3:    letter_ok = tok.is_l;
            3'd4:    letter_ok = tok.is_l;
            default: letter_ok = 1'b0;
        endcase
    end

    // Time digits are kept as six BCD digits and converted at the line end.
    always_comb
    begin
        hour_utc   = ({3'd0, bcd_reg[23:20]} << 3) + ({3'd0, bcd_reg[23:20]} << 1)
                     + {3'd0, bcd_reg[19:16]};
        minute_bin = ({3'd0, bcd_reg[15:12]} << 3) + ({3'd0, bcd_reg[15:12]} << 1)
                     + {3'd0, bcd_reg[11:8]};
        second_bin = ({3'd0, bcd_reg[7:4]} << 3) + ({3'd0, bcd_reg[7:4]} << 1)
                     + {3'd0, bcd_reg[3:0]};
        hour_sum   = $signed({1'b0, hour_utc}) + $signed({{3{tz[4]}}, tz});
        if (hour_sum > 8'sd63)
        begin
            hour_out = 7'd63;
        end
        else if (hour_sum < -8'sd64)
        begin
            hour_out = 7'h40;
        end
        else
        begin
            hour_out = hour_sum[6:0];
        end
    end

    // Result fields of the sentence that is closing.
    always_comb
    begin
        pos = tmatch_reg && (field_reg != 3'd0);
        tv  = pos && (tdig_reg != 3'd0);
        ok  = after_star_reg ? (!hex_bad_reg && (hex_cnt_reg == nmea_pkg::HEX_DIGITS)
                                && (hex_reg == xor_reg)) : 1'b1;
    end

    // Per-token state update.
    always_comb
    begin
        after_star_next = after_star_reg;
        xor_next        = xor_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_next        = hex_reg;
        hex_bad_next    = hex_bad_reg;
        field_next      = field_reg;
        tpos_next       = tpos_reg;
        tmatch_next     = tmatch_reg;
        tdig_next       = tdig_reg;
        tstop_next      = tstop_reg;
        bcd_next        = bcd_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (tok_pop)
        begin
            unique case (tok.kind)
                nmea_pkg::TOK_START:
                begin
                    after_star_next = 1'b0;
                    xor_next        = 8'd0;
                    hex_cnt_next    = 2'd0;
                    hex_next        = 8'd0;
                    hex_bad_next    = 1'b0;
                    field_next      = 3'd0;
                    tpos_next       = 3'd0;
                    tmatch_next     = 1'b1;
                    tdig_next       = 3'd0;
                    tstop_next      = 1'b0;
                    bcd_next        = 24'd0;
                end
                nmea_pkg::TOK_END:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0,
                                      tv ? second_bin : 7'd0,
                                      tv ? minute_bin : 7'd0,
                                      tv ? hour_out : 7'd0,
                                      tv, pos,
                                      after_star_reg ? hex_reg : 8'd0,
                                      xor_reg,
                                      after_star_reg, ok};
                end
                nmea_pkg::TOK_CHAR:
                begin
                    if (!after_star_reg)
                    begin
                        if (tok.is_star)
                        begin
                            after_star_next = 1'b1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ tok.ch;
                            if (tok.is_comma)
                            begin
                                if ((field_reg == 3'd0) && (tpos_reg != nmea_pkg::TALKER_LEN))
                                begin
                                    tmatch_next = 1'b0;
                                end
                                if (field_reg == nmea_pkg::TIME_FIELD)
                                begin
                                    tstop_next = 1'b1;
                                end
                                if (field_reg != nmea_pkg::FIELD_MAX)
                                begin
                                    field_next = field_reg + 1'b1;
                                end
                            end
                            else if (field_reg == 3'd0)
                            begin
                                if (!letter_ok)
                                begin
                                    tmatch_next = 1'b0;
                                end
                                if (tpos_reg != nmea_pkg::TOKEN_MAX)
                                begin
                                    tpos_next = tpos_reg + 1'b1;
                                end
                            end
                            else if ((field_reg == nmea_pkg::TIME_FIELD) && !tstop_reg)
                            begin
                                if (tok.is_digit && (tdig_reg < nmea_pkg::TIME_DIGITS))
                                begin
                                    bcd_next  = {bcd_reg[19:0], tok.hex_val};
                                    tdig_next = tdig_reg + 1'b1;
                                end
                                else
                                begin
                                    tstop_next = 1'b1;
                                end
                            end
                        end
                    end
                    else if (hex_cnt_reg < nmea_pkg::HEX_DIGITS)
                    begin
                        // A bad digit shifts in as zero and spoils the match.
                        hex_next     = {hex_reg[3:0], tok.hex_ok ? tok.hex_val : 4'd0};
                        hex_bad_next = hex_bad_reg || !tok.hex_ok;
                        hex_cnt_next = hex_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
    end

    // Sentence accumulators carry no reset; a start token clears them.
    always_ff @(posedge clk)
    begin
        xor_reg      <= xor_next;
        hex_reg      <= hex_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_star_reg <= 1'b0;
            hex_cnt_reg    <= 2'd0;
            hex_bad_reg    <= 1'b0;
            field_reg      <= 3'd0;
            tpos_reg       <= 3'd0;
            tmatch_reg     <= 1'b1;
            tdig_reg       <= 3'd0;
            tstop_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            after_star_reg <= after_star_next;
            hex_cnt_reg    <= hex_cnt_next;
            hex_bad_reg    <= hex_bad_next;
            field_reg      <= field_next;
            tpos_reg       <= tpos_next;
            tmatch_reg     <= tmatch_next;
            tdig_reg       <= tdig_next;
            tstop_reg      <= tstop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

>>> sv/nmea_sentence_checker.sv
// Top level of the NMEA sentence checker: timezone register, front end, queue, back end.
// Depends on nmea_pkg, nmea_front, nmea_queue and nmea_back.
//
//   Channel   Signals                      Content
//   --------  ---------------------------  -----------------------------------------
//   input     s_tvalid s_tready s_tdata    one received character, 8 bits
//   output    m_tvalid m_tready m_tdata    one result per line end, 48 bits
//   config    cfg_valid cfg_ready cfg_data signed timezone in hours, 5 bits
//
// One character is taken per cycle while the queue is not full; back-end updates set that rate.
// A result shows on m_tdata once the CR or LF that ends a line has passed the token queue
// and the result register, later when earlier tokens wait or an earlier result is stalled.
// Reset clears the framing and sets the timezone to +2 hours.
// A four-entry token queue absorbs output stalls; s_tready falls only when it is full.
module nmea_sentence_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: rx_byte[7:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // tdata: sentence_ok[0], has_checksum[1], computed_sum[9:2], received_sum[17:10],
    //        is_position[18], time_valid[19], hour_local[26:20], minute_value[33:27],
    //        second_value[40:34], zero fill[47:41]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nmea_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic signed [4:0]               cfg_data
);

    logic signed [4:0] tz_reg;
    logic              front_push;
    nmea_pkg::token_t  front_tok;
    logic              queue_full;
    logic              queue_empty;
    nmea_pkg::token_t  queue_tok;
    logic              back_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;

    // Timezone register, written by a configuration transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg <= nmea_pkg::TZ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tz_reg <= cfg_data;
        end
    end

    nmea_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid && s_tready),
        .in_byte  (s_tdata),
        .push     (front_push),
        .tok      (front_tok)
    );

    nmea_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_tok (front_tok),
        .full     (queue_full),
        .pop      (back_pop),
        .pop_tok  (queue_tok),
        .empty    (queue_empty)
    );

    nmea_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!queue_empty),
        .tok       (queue_tok),
        .tok_pop   (back_pop),
        .tz        (tz_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> sv/nmea_sentence_checker_sva.sv
// Port-level checks for the NMEA sentence checker, attached by the bind below.
// Depends on nmea_pkg and on the nmea_sentence_checker ports.
module nmea_sentence_checker_sva (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nmea_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The fill bits above the last field are zero.
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:41] == 7'd0))
        else $error("fill bits of the result are not zero");

    // Without time digits the time fields read zero.
    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[19] |-> (m_tdata[40:20] == 21'd0))
        else $error("time fields set without a valid time");

    // A time is only reported for a position sentence.
    a_time_needs_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> m_tdata[18])
        else $error("time reported for a sentence that is not a position");

    // A sentence without a star always passes and reports no received sum.
    a_no_star_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[0] && (m_tdata[17:10] == 8'd0))
        else $error("sentence without checksum reported as failed");

endmodule

bind nmea_sentence_checker nmea_sentence_checker_sva u_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_nmea_sentence_checker.sv
// Self-checking testbench for the NMEA sentence checker.
// Needs nmea_pkg and the nmea_sentence_checker RTL; drives characters, timezone writes
// and output stalls, and scores every result against a line-level predictor.
`timescale 1ns / 100ps

module tb_nmea_sentence_checker;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 12;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 190;
    localparam int PHASE_LINES    = 6;

    // Checksum tail appended to a generated sentence.
    typedef enum int {
        SUM_NONE,
        SUM_UPPER,
        SUM_LOWER,
        SUM_WRONG,
        SUM_BAD_DIGIT,
        SUM_SHORT,
        SUM_TRAILING
    } sum_mode_t;

    // Line terminator of a generated sentence.
    typedef enum int {
        END_CR,
        END_LF,
        END_CRLF
    } line_end_t;

    // Result fields, last field in the highest bits, matching m_tdata[40:0].
    typedef struct packed {
        logic [6:0] second_value;
        logic [6:0] minute_value;
        logic [6:0] hour_local;
        logic       time_valid;
        logic       is_position;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic       has_checksum;
        logic       sentence_ok;
    } sentence_result_t;

    // Tracks sentence framing per accepted character and holds the predicted line results.
    class sentence_scoreboard;
        logic signed [4:0] timezone;
        bit                listening;
        bit                after_star;
        bit                hex_bad;
        bit                token_ok;
        bit                time_stopped;
        logic [7:0]        xor_acc;
        logic [7:0]        hex_value;
        int                hex_count;
        int                field_no;
        int                token_pos;
        int                digit_count;
        int                hour_acc;
        int                minute_acc;
        int                second_acc;
        sentence_result_t  line_results[$];
        int                errors;

        function new();
            timezone  = nmea_pkg::TZ_RESET;
            listening = 0;
            errors    = 0;
            clear_line();
        endfunction

        function void clear_line();
            after_star   = 0;
            hex_bad      = 0;
            token_ok     = 1;
            time_stopped = 0;
            xor_acc      = '0;
            hex_value    = '0;
            hex_count    = 0;
            field_no     = 0;
            token_pos    = 0;
            digit_count  = 0;
            hour_acc     = 0;
            minute_acc   = 0;
            second_acc   = 0;
        endfunction

        function void set_timezone(logic signed [4:0] hours);
            timezone = hours;
        endfunction

        function int pending();
            return line_results.size();
        endfunction

        // Field and talker tracking for text before the star.
        function void track_field(logic [7:0] c);
            bit ok;
            if (c == nmea_pkg::CHAR_COMMA)
            begin
                if (field_no == 0 && token_pos != nmea_pkg::TALKER_LEN)
                    token_ok = 0;
                if (field_no == nmea_pkg::TIME_FIELD)
                    time_stopped = 1;
                if (field_no < nmea_pkg::FIELD_MAX)
                    field_no++;
                return;
            end
            if (field_no == 0)
            begin
                case (token_pos)
                    0:       ok = (c == nmea_pkg::CHAR_G);
                    1:       ok = (c == nmea_pkg::CHAR_N || c == nmea_pkg::CHAR_P);
                    2:       ok = (c == nmea_pkg::CHAR_G);
                    3:       ok = (c == nmea_pkg::CHAR_L);
                    4:       ok = (c == nmea_pkg::CHAR_L);
                    default: ok = 0;
                endcase
                if (!ok)
                    token_ok = 0;
                if (token_pos < nmea_pkg::TOKEN_MAX)
                    token_pos++;
            end
            else if (field_no == nmea_pkg::TIME_FIELD && !time_stopped)
            begin
                // Digits shift in right-aligned across hour, minute and second.
                if (c >= nmea_pkg::CHAR_0 && c <= nmea_pkg::CHAR_9
                    && digit_count < nmea_pkg::TIME_DIGITS)
                begin
                    hour_acc    = hour_acc * 10 + minute_acc / 10;
                    minute_acc  = (minute_acc % 10) * 10 + second_acc / 10;
                    second_acc  = (second_acc % 10) * 10 + (c - nmea_pkg::CHAR_0);
                    digit_count++;
                end
                else
                    time_stopped = 1;
            end
        endfunction

        // Builds the result that a line end produces from the current sentence state.
        function sentence_result_t close_line();
            sentence_result_t r;
            int hour;
            r = '0;
            r.has_checksum = after_star;
            r.computed_sum = xor_acc;
            r.received_sum = after_star ? hex_value : 8'd0;
            r.sentence_ok  = after_star ? (!hex_bad && hex_count == nmea_pkg::HEX_DIGITS &&
                                           hex_value == xor_acc) : 1'b1;
            r.is_position  = token_ok && field_no >= 1;
            r.time_valid   = r.is_position && digit_count > 0;
            if (r.time_valid)
            begin
                hour = hour_acc + int'(timezone);
                if (hour > 63)
                    hour = 63;
                if (hour < -64)
                    hour = -64;
                r.hour_local   = hour[6:0];
                r.minute_value = minute_acc[6:0];
                r.second_value = second_acc[6:0];
            end
            return r;
        endfunction

        // Called for every accepted character.
        function void note_byte(logic [7:0] c);
            int nib;
            if (!listening)
            begin
                if (c == nmea_pkg::CHAR_DOLLAR)
                begin
                    listening = 1;
                    clear_line();
                end
                return;
            end
            if (c == nmea_pkg::CHAR_CR || c == nmea_pkg::CHAR_LF)
            begin
                line_results.push_back(close_line());
                listening = 0;
                return;
            end
            if (!after_star)
            begin
                if (c == nmea_pkg::CHAR_STAR)
                    after_star = 1;
                else
                begin
                    xor_acc ^= c;
                    track_field(c);
                end
            end
            else if (hex_count < nmea_pkg::HEX_DIGITS)
            begin
                if (c >= nmea_pkg::CHAR_0 && c <= nmea_pkg::CHAR_9)
                    nib = c - nmea_pkg::CHAR_0;
                else if (c >= nmea_pkg::CHAR_UA && c <= nmea_pkg::CHAR_UF)
                    nib = c - nmea_pkg::CHAR_UA + 10;
                else if (c >= nmea_pkg::CHAR_LA && c <= nmea_pkg::CHAR_LF_HEX)
                    nib = c - nmea_pkg::CHAR_LA + 10;
                else
                begin
                    hex_bad = 1;
                    nib     = 0;
                end
                hex_value = {hex_value[3:0], nib[3:0]};
                hex_count++;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [nmea_pkg::OUT_DATA_W-1:0] word);
            sentence_result_t want;
            sentence_result_t got;
            if (line_results.size() == 0)
            begin
                $error("result %h arrived with no line end pending", word);
                errors++;
                return;
            end
            want = line_results.pop_front();
            got  = word[40:0];
            compare_field("sentence_ok", want.sentence_ok, got.sentence_ok);
            compare_field("has_checksum", want.has_checksum, got.has_checksum);
            compare_field("computed_sum", want.computed_sum, got.computed_sum);
            compare_field("received_sum", want.received_sum, got.received_sum);
            compare_field("is_position", want.is_position, got.is_position);
            compare_field("time_valid", want.time_valid, got.time_valid);
            compare_field("hour_local", $signed(want.hour_local), $signed(got.hour_local));
            compare_field("minute_value", want.minute_value, got.minute_value);
            compare_field("second_value", want.second_value, got.second_value);
            compare_field("zero_fill", 0, word[nmea_pkg::OUT_DATA_W-1:41]);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [nmea_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic signed [4:0]               cfg_data;

    sentence_scoreboard sb;
    logic [7:0]         line_q[$];
    bit                 sender_gaps;
    bit                 no_idle;
    bit                 hold_request;
    int                 bytes_sent;
    int                 quiet_cycles;

    nmea_sentence_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one character and waits for its transfer; an optional gap comes first.
    task automatic send_byte(input logic [7:0] c);
        if (sender_gaps && !no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(c);
        bytes_sent++;
    endtask

    // Writes the timezone register while the block is idle.
    task automatic write_timezone(input int hours);
        cfg_valid <= 1'b1;
        cfg_data  <= hours[4:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_timezone(hours[4:0]);
    endtask

    // Stops offering and waits until every pending result has come and the pipe is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic add_digits(input int count);
        repeat (count) line_q.push_back(8'(nmea_pkg::CHAR_0 + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 10)
            return nmea_pkg::CHAR_0 + nib;
        return (lower ? nmea_pkg::CHAR_LA : nmea_pkg::CHAR_UA) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == nmea_pkg::CHAR_CR || c == nmea_pkg::CHAR_LF || c == nmea_pkg::CHAR_STAR);
        return c;
    endfunction

    // Sends '$', the queued body, the checksum tail that the mode asks for and the line end, then clears the body.
    task automatic send_line(input sum_mode_t mode, input line_end_t ending);
        logic [7:0] line_sum;
        logic [7:0] bad;
        bit         stop;
        string      tail;
        line_sum = '0;
        stop     = 0;
        tail     = "*5,x";
        foreach (line_q[i])
        begin
            if (line_q[i] == nmea_pkg::CHAR_STAR)
                stop = 1;
            if (!stop)
                line_sum ^= line_q[i];
        end
        send_byte(nmea_pkg::CHAR_DOLLAR);
        foreach (line_q[i])
            send_byte(line_q[i]);
        if (mode == SUM_WRONG)
            line_sum ^= 8'($urandom_range(1, 255));
        if (mode != SUM_NONE)
            send_byte(nmea_pkg::CHAR_STAR);
        case (mode) inside
            SUM_UPPER, SUM_WRONG, SUM_TRAILING:
            begin
                send_byte(hex_char(line_sum[7:4], 0));
                send_byte(hex_char(line_sum[3:0], 0));
                if (mode == SUM_TRAILING)
                    for (int i = 0; i < tail.len(); i++)
                        send_byte(tail[i]);
            end
            SUM_LOWER:
            begin
                send_byte(hex_char(line_sum[7:4], 1));
                send_byte(hex_char(line_sum[3:0], 1));
            end
            SUM_BAD_DIGIT:
            begin
                // A random character, which may by chance be a hex digit, in either digit place.
                bad = random_text_byte();
                if ($urandom_range(0, 1) == 0)
                begin
                    send_byte(bad);
                    send_byte(hex_char(line_sum[3:0], 0));
                end
                else
                begin
                    send_byte(hex_char(line_sum[7:4], 0));
                    send_byte(bad);
                end
            end
            SUM_SHORT:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(hex_char(line_sum[7:4], 0));
            end
            default: ;
        endcase
        case (ending)
            END_CR:  send_byte(nmea_pkg::CHAR_CR);
            END_LF:  send_byte(nmea_pkg::CHAR_LF);
            default:
            begin
                send_byte(nmea_pkg::CHAR_CR);
                send_byte(nmea_pkg::CHAR_LF);
            end
        endcase
        line_q.delete();
    endtask

    // Queues a random body: mostly position sentences with random content, some noise.
    task automatic random_body();
        int fields_before_time;
        if ($urandom_range(0, 99) < 70)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: add_text("GPGLL");
                5, 6, 7, 8:    add_text("GNGLL");
                9:             add_text("GPGL");
                10:            add_text("GPGLLA");
                default:
                    repeat ($urandom_range(0, 6)) line_q.push_back(random_text_byte());
            endcase
            fields_before_time = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 4;
            repeat (fields_before_time)
            begin
                add_text(",");
                add_digits($urandom_range(0, 4));
            end
            add_text(",");
            // The time field: a few digits, often a fraction, sometimes a random character.
            add_digits($urandom_range(0, 8));
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    add_text(".");
                    add_digits(2);
                end
                2:       line_q.push_back(random_text_byte());
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                add_text(",A,A");
            if ($urandom_range(0, 5) == 0)
                add_text(",,,,");
        end
        else
            repeat ($urandom_range(0, 12)) line_q.push_back(random_text_byte());
    endtask

    function automatic sum_mode_t random_sum_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return SUM_NONE;
        if (r < 60)
            return SUM_UPPER;
        if (r < 70)
            return SUM_LOWER;
        if (r < 80)
            return SUM_WRONG;
        if (r < 88)
            return SUM_BAD_DIGIT;
        if (r < 94)
            return SUM_SHORT;
        return SUM_TRAILING;
    endfunction

    // One random stretch of lines, with stray bytes between some of them.
    task automatic run_random(input int byte_goal);
        int start_count;
        int lines;
        start_count = bytes_sent;
        lines       = 0;
        while (bytes_sent - start_count < byte_goal || lines < PHASE_LINES)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            random_body();
            send_line(random_sum_mode(), line_end_t'($urandom_range(0, 2)));
            lines++;
        end
    endtask

    // Output side: random stalls, one long hold-off on request, none at the end.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Every result transfer is scored.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nmea_sentence_checker: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence.
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        sender_gaps  = 0;
        no_idle      = 0;
        hold_request = 0;
        bytes_sent   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sentences under the reset timezone; idle CR and LF give nothing.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(nmea_pkg::CHAR_LF);
        send_byte(nmea_pkg::CHAR_CR);
        add_text("GPGLL,4916.45,N,12311.12,W,225444.00,A");
        send_line(SUM_UPPER, END_CRLF);
        add_text("GNGLL,,,,,995959,A");
        send_line(SUM_LOWER, END_LF);
        add_text("GPGLL,,,,,1234.5");
        send_line(SUM_NONE, END_CR);
        add_text("GPGLL,,,,,000000");
        send_line(SUM_WRONG, END_LF);
        add_text("GNGLL,,,,,1234567");
        send_line(SUM_BAD_DIGIT, END_CR);
        add_text("GPGL,,,,,123456");
        send_line(SUM_SHORT, END_LF);
        add_text("GPGLLX,,,,,12");
        send_line(SUM_TRAILING, END_LF);
        add_text("GPGLL,,,,,A12");
        send_line(SUM_UPPER, END_CR);
        add_text("G$P,,,,,,,,,,");
        send_line(SUM_UPPER, END_LF);
        send_line(SUM_NONE, END_LF);
        settle();

        // Random phases at several timezones; the second one starts with a long output stall.
        write_timezone(14);
        run_random(PHASE_BYTES);
        settle();
        write_timezone(-12);
        hold_request = 1;
        run_random(PHASE_BYTES);
        settle();
        write_timezone($urandom_range(0, 26) - 12);
        run_random(PHASE_BYTES);
        settle();
        write_timezone(0);
        no_idle = 1;
        run_random(PHASE_BYTES);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("nmea_sentence_checker: match");
        else
            $display("nmea_sentence_checker: mismatch");
        $finish;
    end

endmodule

>>> nmea_sentence_checker.f
sv/nmea_pkg.sv
sv/nmea_front.sv
sv/nmea_queue.sv
sv/nmea_back.sv
sv/nmea_sentence_checker.sv
sv/nmea_sentence_checker_sva.sv
bench/tb_nmea_sentence_checker.sv
